>>> design/ehys_pkg.sv
// Shared types, constants and table functions for the exponential hardening unit.
// Used by every module of the block; no dependencies of its own.
package ehys_pkg;

  localparam int EXP_TABLE_ENTRIES_DEFAULT = 256;
  localparam int TAYLOR_TERMS = 20;
  localparam int POW_ENTRIES = 32;

  localparam int STRAIN_W = 32;
  localparam int YIELD_W  = 40;
  localparam int SLOPE_W  = 48;
  localparam int LIN_W    = 36;

  typedef enum logic [1:0] {
    REG_INITIAL_YIELD   = 2'd0,
    REG_SATURATED_YIELD = 2'd1,
    REG_LINEAR_MODULUS  = 2'd2,
    REG_SATURATION_RATE = 2'd3
  } ehys_reg_t;

  typedef struct packed {
    logic [30:0]        initial_yield;
    logic [30:0]        saturated_yield;
    logic signed [31:0] linear_modulus;
    logic [31:0]        saturation_rate;
  } ehys_cfg_t;

  // sideband that travels alongside the exponential path
  typedef struct packed {
    logic                    neg;
    logic signed [LIN_W-1:0] lin;
  } ehys_side_t;

  // exp(-t) for t in Q31, 0 <= t <= 1.0, by truncated Taylor series; result Q31
  function automatic logic [31:0] exp_neg_frac(input logic [63:0] t);
    logic signed [63:0] sum;
    logic [63:0]        term;
    sum  = 64'sd2147483648;
    term = 64'd1 << 31;
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      term = ((term * t) >> 31) / 64'(k);
      if (k[0]) sum = sum - $signed(term);
      else      sum = sum + $signed(term);
    end
    if (sum < 0) sum = 64'sd0;
    return sum[31:0];
  endfunction

  // exp(-k) in Q31, built by repeated rounded multiplication by exp(-1)
  function automatic logic [31:0] pow_entry(input int k);
    logic [63:0] p;
    logic [63:0] fn;
    p  = 64'd1 << 31;
    fn = {32'd0, exp_neg_frac(64'd1 << 31)};
    for (int j = 1; j <= k; j++) begin
      p = (p * fn + (64'd1 << 30)) >> 31;
    end
    return p[31:0];
  endfunction

endpackage

>>> design/ehys_front.sv
// Front end: strain magnitude, exponent argument and linear hardening term.
// Three register stages; uses ehys_pkg.
module ehys_front import ehys_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  ehys_cfg_t           cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [STRAIN_W-1:0] in_strain,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [63:0]         out_x,
  output ehys_side_t          out_side
);

  logic        v1, v2, v3;
  logic        rdy1, rdy2, rdy3;
  logic [31:0] m1;
  logic        neg1, neg2;
  logic [63:0] x2, lp2, x3;
  ehys_side_t  side3;

  logic [31:0]        m_in;
  logic [31:0]        lm_bits;
  logic [31:0]        ep_mag;
  logic [63:0]        lin_sum;
  logic [34:0]        lin_mag;
  logic signed [35:0] lin_val;

  assign rdy3 = !v3 || out_ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;

  // most negative strain maps to magnitude 2^31, which still fits
  assign m_in    = in_strain[31] ? (~in_strain + 32'd1) : in_strain;
  assign lm_bits = cfg.linear_modulus;
  assign ep_mag  = lm_bits[31] ? (~lm_bits + 32'd1) : lm_bits;

  assign lin_sum = lp2 + (64'd1 << 27);
  assign lin_mag = lin_sum[62:28];
  assign lin_val = lm_bits[31] ? -$signed({1'b0, lin_mag}) : $signed({1'b0, lin_mag});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
    if (rdy1) begin
      m1   <= m_in;
      neg1 <= in_strain[31];
    end
    if (rdy2) begin
      x2   <= m1 * cfg.saturation_rate;
      lp2  <= m1 * ep_mag;
      neg2 <= neg1;
    end
    if (rdy3) begin
      x3        <= x2;
      side3.neg <= neg2;
      side3.lin <= lin_val;
    end
  end

  assign out_valid = v3;
  assign out_x     = x3;
  assign out_side  = side3;

endmodule

>>> design/ehys_exp.sv
// Shared exponential exp(-x), x in Q16.48: table lookup, linear interpolation,
// integer-power scaling. Four register stages; uses ehys_pkg tables.
module ehys_exp import ehys_pkg::*; #(
  parameter int EXP_TABLE_ENTRIES = EXP_TABLE_ENTRIES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_x,
  input  ehys_side_t  in_side,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_e,
  output ehys_side_t  out_side
);

  localparam int IDX_W  = $clog2(EXP_TABLE_ENTRIES);
  localparam int ADDR_W = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int POS_W  = 48 + IDX_W;

  logic [31:0] frac_tab [EXP_TABLE_ENTRIES + 1];
  logic [31:0] pow_tab  [POW_ENTRIES];

  for (genvar g = 0; g <= EXP_TABLE_ENTRIES; g++) begin : g_frac
    localparam logic [63:0] FRAC_ARG = (64'(g) << 31) / EXP_TABLE_ENTRIES;
    assign frac_tab[g] = exp_neg_frac(FRAC_ARG);
  end

  for (genvar g = 0; g < POW_ENTRIES; g++) begin : g_pow
    assign pow_tab[g] = pow_entry(g);
  end

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  logic [POS_W-1:0]  pos;
  logic [IDX_W-1:0]  idx;
  logic [ADDR_W-1:0] addr_lo, addr_hi;
  logic              kbig_in;

  logic [31:0] a1, b1, pk1;
  logic [30:0] w1;
  logic        kbig1;
  ehys_side_t  side1;

  logic        ge;
  logic [31:0] dab;
  logic [31:0] a2, pk2;
  logic        ge2, kbig2;
  logic [62:0] prod2;
  ehys_side_t  side2;

  logic [31:0] dq, v_int;
  logic [63:0] eprod3;
  logic        kbig3;
  ehys_side_t  side3;

  logic [63:0] esum;
  logic [31:0] e4;
  ehys_side_t  side4;

  assign rdy4 = !v4 || out_ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;

  assign pos     = POS_W'(in_x[47:0]) * POS_W'(EXP_TABLE_ENTRIES);
  assign idx     = pos[POS_W-1:48];
  assign addr_lo = ADDR_W'(idx);
  assign addr_hi = addr_lo + ADDR_W'(1);
  // integer part of 32 or more underflows to zero
  assign kbig_in = |in_x[63:53];

  assign ge  = a1 >= b1;
  assign dab = ge ? (a1 - b1) : (b1 - a1);

  assign dq    = prod2[62:31];
  assign v_int = ge2 ? (a2 - dq) : (a2 + dq);

  assign esum = eprod3 + (64'd1 << 30);

  always_comb begin
    e4 = esum[62:31];
    if (kbig3) e4 = 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
    if (rdy1) begin
      a1    <= frac_tab[addr_lo];
      b1    <= frac_tab[addr_hi];
      w1    <= pos[47:17];
      pk1   <= pow_tab[in_x[52:48]];
      kbig1 <= kbig_in;
      side1 <= in_side;
    end
    if (rdy2) begin
      a2    <= a1;
      ge2   <= ge;
      prod2 <= dab * w1;
      pk2   <= pk1;
      kbig2 <= kbig1;
      side2 <= side1;
    end
    if (rdy3) begin
      eprod3 <= pk2 * v_int;
      kbig3  <= kbig2;
      side3  <= side2;
    end
    if (rdy4) begin
      out_e <= e4;
      side4 <= side3;
    end
  end

  assign out_valid = v4;
  assign out_side  = side4;

endmodule

>>> design/ehys_back.sv
// Back end: saturation and slope terms from the shared exponential, final sums
// and clamping. Three register stages, the last is the output register; uses ehys_pkg.
module ehys_back import ehys_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  ehys_cfg_t          cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_e,
  input  ehys_side_t         in_side,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [YIELD_W-1:0] out_yield,
  output logic [SLOPE_W-1:0] out_slope,
  output logic               out_neg
);

  localparam logic signed [41:0] Y_MAX  = 42'sd549755813887;
  localparam logic signed [41:0] Y_MIN  = -42'sd549755813888;
  localparam logic signed [49:0] DY_MAX = 50'sd140737488355327;
  localparam logic signed [49:0] DY_MIN = -50'sd140737488355328;

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  logic [31:0] d_bits;
  logic        d_neg;
  logic [30:0] d_mag;

  logic [31:0] ome;
  logic [62:0] sp1;
  logic [63:0] dp1;
  ehys_side_t  side1;

  logic [63:0]        ssum, dsum;
  logic [31:0]        sat_mag;
  logic [32:0]        de;
  logic signed [32:0] sat_val;
  logic signed [32:0] sat2;
  logic [63:0]        slp2;
  ehys_side_t         side2;

  logic [63:0]        slsum;
  logic [43:0]        slope_mag;
  logic signed [44:0] slope_val;
  logic signed [41:0] y_sum;
  logic signed [49:0] dy_sum;
  logic [YIELD_W-1:0] y_clamped;
  logic [SLOPE_W-1:0] dy_clamped;

  assign rdy3 = !v3 || out_ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;

  assign d_bits = {1'b0, cfg.saturated_yield} - {1'b0, cfg.initial_yield};
  assign d_neg  = d_bits[31];
  assign d_mag  = d_neg ? 31'(~d_bits + 32'd1) : d_bits[30:0];

  assign ome = 32'h8000_0000 - in_e;

  assign ssum    = {1'b0, sp1} + (64'd1 << 30);
  assign sat_mag = ssum[62:31];
  assign sat_val = d_neg ? -$signed({1'b0, sat_mag}) : $signed({1'b0, sat_mag});
  assign dsum    = dp1 + (64'd1 << 30);
  assign de      = dsum[63:31];

  assign slsum     = slp2 + (64'd1 << 19);
  assign slope_mag = slsum[63:20];
  assign slope_val = d_neg ? -$signed({1'b0, slope_mag}) : $signed({1'b0, slope_mag});

  assign y_sum  = $signed({11'd0, cfg.initial_yield}) + 42'(side2.lin) + 42'(sat2);
  assign dy_sum = 50'(cfg.linear_modulus) + 50'(slope_val);

  always_comb begin
    y_clamped = y_sum[YIELD_W-1:0];
    if (y_sum > Y_MAX) y_clamped = Y_MAX[YIELD_W-1:0];
    if (y_sum < Y_MIN) y_clamped = Y_MIN[YIELD_W-1:0];
    dy_clamped = dy_sum[SLOPE_W-1:0];
    if (dy_sum > DY_MAX) dy_clamped = DY_MAX[SLOPE_W-1:0];
    if (dy_sum < DY_MIN) dy_clamped = DY_MIN[SLOPE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
    if (rdy1) begin
      sp1   <= d_mag * ome;
      dp1   <= cfg.saturation_rate * in_e;
      side1 <= in_side;
    end
    if (rdy2) begin
      sat2  <= sat_val;
      slp2  <= d_mag * de;
      side2 <= side1;
    end
    if (rdy3) begin
      out_yield <= y_clamped;
      out_slope <= dy_clamped;
      out_neg   <= side2.neg;
    end
  end

  assign out_valid = v3;

endmodule

>>> design/exp_hardening_yield_stress_unit.sv
// Exponential-plus-linear hardening law: yield stress and slope per strain sample.
// Pipeline: 10 register stages (front 3, exp 4, back 3).
// Throughput: one sample per cycle while the output accepts; each stage holds at most one
// multiplier step and a valid bit, and a stalled output backs up only stages that are full.
// Reset: clears all valid bits and loads register defaults; tables are constant logic.
module exp_hardening_yield_stress_unit import ehys_pkg::*; #(
  parameter int EXP_TABLE_ENTRIES = EXP_TABLE_ENTRIES_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [STRAIN_W-1:0]        s_tdata,   // [31:0] plastic_strain
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [YIELD_W+SLOPE_W-1:0] m_tdata,   // [39:0] yield_stress, [87:40] hardening_slope
  output logic [0:0]                 m_tuser,   // [0] strain_was_negative
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [31:0]                cfg_data
);

  ehys_cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_yield   <= 31'd250000;
      cfg.saturated_yield <= 31'd400000;
      cfg.linear_modulus  <= 32'sd1000000;
      cfg.saturation_rate <= 32'd10485760;
    end else if (cfg_valid) begin
      case (ehys_reg_t'(cfg_index))
        REG_INITIAL_YIELD:   cfg.initial_yield   <= cfg_data[30:0];
        REG_SATURATED_YIELD: cfg.saturated_yield <= cfg_data[30:0];
        REG_LINEAR_MODULUS:  cfg.linear_modulus  <= $signed(cfg_data);
        REG_SATURATION_RATE: cfg.saturation_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  logic        f_valid, f_ready;
  logic [63:0] f_x;
  ehys_side_t  f_side;
  logic        e_valid, e_ready;
  logic [31:0] e_val;
  ehys_side_t  e_side;
  logic [YIELD_W-1:0] y_out;
  logic [SLOPE_W-1:0] dy_out;
  logic               neg_out;

  ehys_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_strain (s_tdata),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_x     (f_x),
    .out_side  (f_side)
  );

  ehys_exp #(
    .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
  ) u_exp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_x      (f_x),
    .in_side   (f_side),
    .out_valid (e_valid),
    .out_ready (e_ready),
    .out_e     (e_val),
    .out_side  (e_side)
  );

  ehys_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (e_valid),
    .in_ready  (e_ready),
    .in_e      (e_val),
    .in_side   (e_side),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_yield (y_out),
    .out_slope (dy_out),
    .out_neg   (neg_out)
  );

  assign m_tdata = {dy_out, y_out};
  assign m_tuser = neg_out;

endmodule

>>> design/ehys_checker.sv
// Port-level checks for exp_hardening_yield_stress_unit, attached by bind.
// Depends on ehys_pkg for field widths.
module ehys_checker import ehys_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [YIELD_W+SLOPE_W-1:0] m_tdata,
  input logic [0:0]                 m_tuser
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // an empty output register means no stage can be blocked
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output register empty");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped before transfer");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind exp_hardening_yield_stress_unit ehys_checker u_ehys_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> bench/tb_exp_hardening_yield_stress_unit.sv
// Self-checking bench for exp_hardening_yield_stress_unit: streams strain samples through the
// block under several register settings, checking each result against a known row or predictor.
// Depends on ehys_pkg (types, register codes, field widths) and the unit itself.
module tb_exp_hardening_yield_stress_unit;
  import ehys_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EXP_N       = EXP_TABLE_ENTRIES_DEFAULT;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_WAIT  = 14;
  localparam int NUM_DIRECTED = 18;

  typedef struct packed {
    logic signed [YIELD_W-1:0] ys;
    logic signed [SLOPE_W-1:0] slope;
    logic                      neg;
  } stress_res_t;

  // strain, known flag, then the known result
  typedef struct packed {
    logic [31:0]  strain;
    logic         known;
    stress_res_t  want;
  } strain_row_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [STRAIN_W-1:0]        s_tdata;
  logic                       m_tvalid;
  logic                       m_tready;
  logic [YIELD_W+SLOPE_W-1:0] m_tdata;
  logic [0:0]                 m_tuser;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [1:0]                 cfg_index;
  logic [31:0]                cfg_data;

  ehys_cfg_t    cfg_model;
  logic [63:0]  frac_lut [0:EXP_N];
  logic [63:0]  pow_lut  [0:POW_ENTRIES-1];
  stress_res_t  expected_stress_q [$];
  int           errors = 0;
  bit           burst_mode = 1'b0;
  bit           hold_request = 1'b0;

  // Known rows assume the register values after reset.
  strain_row_t dir_rows [0:NUM_DIRECTED-1] = '{
    '{32'h0000_0000, 1'b1, '{40'sd250000,  48'sd2500000, 1'b0}},
    '{32'h8000_0000, 1'b1, '{40'sd8400000, 48'sd1000000, 1'b1}},
    '{32'h7FFF_FFFF, 1'b1, '{40'sd8400000, 48'sd1000000, 1'b0}},
    '{32'h0000_0001, 1'b0, '{40'sd0, 48'sd0, 1'b0}},
    '{32'hFFFF_FFFF, 1'b0, '{40'sd0, 48'sd0, 1'b0}},
    '{32'h1000_0000, 1'b0, '{40'sd0, 48'sd0, 1'b0}},
    '{32'hF000_0000, 1'b0, '{40'sd0, 48'sd0, 1'b0}},
    '{32'h0000_1000, 1'b0, '{40'sd0, 48'sd0, 1'b0}},
    '{32'h0010_0000, 1'b0, '{40'sd0, 48'sd0, 1'b0}},
    '{32'h0100_0000, 1'b0, '{40'sd0, 48'sd0, 1'b0}},
    '{32'h0200_0000, 1'b0, '{40'sd0, 48'sd0, 1'b0}},
    '{32'h3333_3333, 1'b0, '{40'sd0, 48'sd0, 1'b0}},  // last power-table entry
    '{32'h3333_3334, 1'b0, '{40'sd0, 48'sd0, 1'b0}},  // exponent just past the table
    '{32'h4000_0000, 1'b0, '{40'sd0, 48'sd0, 1'b0}},
    '{32'hC000_0000, 1'b0, '{40'sd0, 48'sd0, 1'b0}},
    '{32'h0000_0002, 1'b0, '{40'sd0, 48'sd0, 1'b0}},
    '{32'h5555_5555, 1'b0, '{40'sd0, 48'sd0, 1'b0}},
    '{32'hAAAA_AAAA, 1'b0, '{40'sd0, 48'sd0, 1'b0}}
  };

  exp_hardening_yield_stress_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------- predictor ----------------

  // exp(-t), t in Q31 over [0, 1], 20-term alternating series, Q31 out
  function automatic logic [63:0] series_exp_q31(input logic [63:0] t);
    longint      acc;
    logic [63:0] term;
    acc  = longint'(64'd1 << 31);
    term = 64'd1 << 31;
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      term = ((term * t) >> 31) / 64'(k);
      if (k % 2 == 1) acc = acc - longint'(term);
      else            acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    return 64'(acc);
  endfunction

  // x in Q16.48: integer part from the power table, fraction interpolated
  function automatic logic [63:0] shared_exp_q31(input logic [63:0] x);
    logic [63:0] mask48, k, pos, idx, w, a, b, v;
    mask48 = (64'd1 << 48) - 1;
    k = x >> 48;
    if (k >= POW_ENTRIES) return 64'd0;
    pos = (x & mask48) * 64'(EXP_N);
    idx = pos >> 48;
    if (idx >= EXP_N) idx = EXP_N - 1;
    w = (pos & mask48) >> 17;
    a = frac_lut[int'(idx)];
    b = frac_lut[int'(idx) + 1];
    v = (a >= b) ? a - (((a - b) * w) >> 31) : a + (((b - a) * w) >> 31);
    return (pow_lut[int'(k)] * v + (64'd1 << 30)) >> 31;
  endfunction

  // round magnitude half up, then restore the sign
  function automatic longint scale_signed(input bit neg, input logic [63:0] mag, input int sh);
    logic [63:0] r;
    r = (mag + (64'd1 << (sh - 1))) >> sh;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint sat_to_width(input longint v, input int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic stress_res_t predict_stress(input logic [31:0] raw);
    stress_res_t res;
    logic [63:0] m, rate, e, ep_mag, d_mag, de;
    longint      lm, iy, sy, diff, lin, sat_term, slope_term, y, dy;
    bit          ep_neg, d_neg;
    m    = raw[31] ? (64'd1 << 32) - {32'd0, raw} : {32'd0, raw};
    rate = {32'd0, cfg_model.saturation_rate};
    e    = shared_exp_q31(m * rate);
    lm   = longint'({{32{cfg_model.linear_modulus[31]}}, cfg_model.linear_modulus});
    iy   = longint'({33'd0, cfg_model.initial_yield});
    sy   = longint'({33'd0, cfg_model.saturated_yield});
    ep_neg = lm < 0;
    ep_mag = ep_neg ? 64'(-lm) : 64'(lm);
    diff   = sy - iy;
    d_neg  = diff < 0;
    d_mag  = d_neg ? 64'(-diff) : 64'(diff);
    lin        = scale_signed(ep_neg, m * ep_mag, 28);
    sat_term   = scale_signed(d_neg, d_mag * ((64'd1 << 31) - e), 31);
    de         = (rate * e + (64'd1 << 30)) >> 31;
    slope_term = scale_signed(d_neg, d_mag * de, 20);
    y  = sat_to_width(iy + lin + sat_term, YIELD_W);
    dy = sat_to_width(lm + slope_term, SLOPE_W);
    res.ys    = y[YIELD_W-1:0];
    res.slope = dy[SLOPE_W-1:0];
    res.neg   = raw[31];
    return res;
  endfunction

  // ---------------- stimulus ----------------

  // valid is left high after a transfer; within this task it drops only when a gap follows
  task automatic send_strain(input logic [31:0] strain, input logic known,
                             input stress_res_t want);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= strain;
    do @(posedge clk); while (!s_tready);
    expected_stress_q.push_back(known ? want : predict_stress(strain));
  endtask

  function automatic logic [31:0] random_strain();
    logic [31:0] mag;
    if ($urandom_range(0, 3) == 0) return $urandom;
    mag = $urandom >> $urandom_range(0, 31);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  // block is idle once nothing is outstanding; DRAIN_WAIT then adds a margin
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_stress_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input ehys_reg_t idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_INITIAL_YIELD:   cfg_model.initial_yield   = value[30:0];
      REG_SATURATED_YIELD: cfg_model.saturated_yield = value[30:0];
      REG_LINEAR_MODULUS:  cfg_model.linear_modulus  = value;
      REG_SATURATION_RATE: cfg_model.saturation_rate = value;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [31:0] iy, input logic [31:0] sy,
                               input logic [31:0] lm, input logic [31:0] rate);
    drain_results();
    write_reg(REG_INITIAL_YIELD, iy);
    write_reg(REG_SATURATED_YIELD, sy);
    write_reg(REG_LINEAR_MODULUS, lm);
    write_reg(REG_SATURATION_RATE, rate);
    cfg_valid <= 1'b0;
  endtask

  task automatic extreme_phase(input logic [31:0] iy, input logic [31:0] sy,
                               input logic [31:0] lm, input logic [31:0] rate);
    load_settings(iy, sy, lm, rate);
    for (int i = 0; i < NUM_DIRECTED; i++) send_strain(dir_rows[i].strain, 1'b0, '0);
    repeat (25) send_strain(random_strain(), 1'b0, '0);
  endtask

  initial begin
    logic [31:0] lm_pick;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_INITIAL_YIELD;
    cfg_data  <= '0;
    cfg_model.initial_yield   = 31'd250000;
    cfg_model.saturated_yield = 31'd400000;
    cfg_model.linear_modulus  = 32'sd1000000;
    cfg_model.saturation_rate = 32'd10485760;
    for (int i = 0; i <= EXP_N; i++)
      frac_lut[i] = series_exp_q31((64'(i) << 31) / 64'(EXP_N));
    pow_lut[0] = 64'd1 << 31;
    for (int i = 1; i < POW_ENTRIES; i++)
      pow_lut[i] = (pow_lut[i-1] * frac_lut[EXP_N] + (64'd1 << 30)) >> 31;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_strain(dir_rows[i].strain, dir_rows[i].known, dir_rows[i].want);

    // top bits above the 31-bit fields must be dropped
    extreme_phase(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    extreme_phase(32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    extreme_phase(32'h0012_3456, 32'h0012_3456, 32'hFFFF_FFFF, 32'h0000_0001);

    for (int ph = 0; ph < 7; ph++) begin
      lm_pick = $urandom_range(0, 1) ? $urandom : $signed($urandom) >>> $urandom_range(0, 31);
      load_settings($urandom, $urandom, lm_pick,
                    (ph == 6) ? 32'd0 : $urandom >> $urandom_range(0, 31));
      burst_mode = (ph == 2 || ph == 5);
      // long output stall while the source keeps pushing back to back
      if (ph == 2) hold_request = 1'b1;
      repeat (100) send_strain(random_strain(), 1'b0, '0);
      burst_mode = 1'b0;
    end

    drain_results();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // ---------------- result side ----------------

  initial begin
    int stall;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 8);
      if (hold_request) begin
        hold_request = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    stress_res_t want;
    stress_res_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.ys    = m_tdata[YIELD_W-1:0];
      got.slope = m_tdata[YIELD_W+SLOPE_W-1:YIELD_W];
      got.neg   = m_tuser[0];
      if (expected_stress_q.size() == 0) begin
        $display("%0t: unexpected result transfer, yield_stress %0d", $time, got.ys);
        errors++;
      end else begin
        want = expected_stress_q.pop_front();
        if (got.ys !== want.ys) begin
          $display("%0t: yield_stress expected %0d got %0d", $time, want.ys, got.ys);
          errors++;
        end
        if (got.slope !== want.slope) begin
          $display("%0t: hardening_slope expected %0d got %0d", $time, want.slope, got.slope);
          errors++;
        end
        if (got.neg !== want.neg) begin
          $display("%0t: strain_was_negative expected %0b got %0b", $time, want.neg, got.neg);
          errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
